>>> sv/sjpd_pkg.sv
// Shared constants and per-channel scale tables for the serial joystick pair decoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sjpd_pkg;

	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned READING_W   = 10;   // reading width, fixed by the link format
	localparam int unsigned CHAN_W      = 3;
	localparam int unsigned POS_W       = 17;
	localparam int unsigned SCALE_W     = 11;
	localparam int unsigned RECIP_W     = 29;
	localparam int unsigned RECIP_SHIFT = 20;   // 2^36 reciprocal, less the 2^16 of the output
	localparam int unsigned PROD_W      = READING_W + RECIP_W;
	localparam int unsigned QUOT_W      = 16;
	localparam int unsigned MAX_ANALOG  = 7;
	localparam int unsigned TDATA_OUT_W = 24;

	localparam logic [CHAN_W-1:0]    BUTTON_CHAN = 3'd7;
	localparam logic [CHAN_W-1:0]    SLIDER_CHAN = 3'd0;
	localparam logic [READING_W-1:0] REST_CENTER = 10'd512;
	localparam logic [POS_W-1:0]     HALF_SCALE  = 17'd32768;

	localparam logic KIND_ANALOG = 1'b0;
	localparam logic KIND_BUTTON = 1'b1;

	// full-scale span per channel
	function automatic logic [SCALE_W-1:0] chan_scale(input logic [CHAN_W-1:0] chan);
		logic [SCALE_W-1:0] s;
		case (chan)
			3'd0:    s = 11'd1019;
			3'd1:    s = 11'd200;
			3'd2:    s = 11'd200;
			3'd3:    s = 11'd350;
			3'd4:    s = 11'd200;
			3'd5:    s = 11'd200;
			3'd6:    s = 11'd350;
			default: s = 11'd200;
		endcase
		return s;
	endfunction

	// ceil(2^36 / scale); exact floor for any 10-bit magnitude times 2^16
	function automatic logic [RECIP_W-1:0] chan_recip(input logic [CHAN_W-1:0] chan);
		logic [RECIP_W-1:0] r;
		case (chan)
			3'd0:    r = 29'd67438152;
			3'd1:    r = 29'd343597384;
			3'd2:    r = 29'd343597384;
			3'd3:    r = 29'd196341363;
			3'd4:    r = 29'd343597384;
			3'd5:    r = 29'd343597384;
			3'd6:    r = 29'd196341363;
			default: r = 29'd343597384;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

>>> sv/serial_joystick_pair_decoder.sv
// Serial joystick pair decoder: byte framing, rest calibration and position scaling.
// Depends on sjpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Frames a stream of serial bytes into two-byte joystick reports. A byte with
// bit 7 clear is a first byte (channel in bits 5..3, reading bits 9..7 in bits
// 2..0); a byte with bit 7 set completes the pair with reading bits 6..0. A new
// first byte replaces a held one; a second byte with nothing held is dropped.
// Channel 7 yields a button report (kind 1, active-low buttons inverted).
// Analog channels below ANALOG_CHANNELS yield (rest - reading) * 65536 / scale,
// truncated toward zero, clamped to +-32768 and negated for the slider
// (channel 0); pairs on channels ANALOG_CHANNELS..6 are swallowed. With the
// calibrate flag set, an analog pair first stores its reading as that
// channel's rest value (the slider always keeps 512). Rest values are 512
// after reset. Throughput is one byte per clock while s_tready stays high: every
// byte goes through an input register, then one pass of framing, a single 10x29
// reciprocal multiply and the clamp into the result register that drives m_tvalid.
// The result register lets input requests that produce no report, or that arrive
// while the register is being drained, keep flowing; only a new report meeting a
// held one with m_tready low stalls s_tready.
module serial_joystick_pair_decoder #(
	parameter int unsigned ANALOG_CHANNELS = sjpd_pkg::MAX_ANALOG
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                s_tvalid,
	output logic                               s_tready,
	input  wire  [sjpd_pkg::BYTE_W-1:0]        s_tdata,   // [7:0] rx_byte
	input  wire                                s_tuser,   // [0] calibrate
	output logic                               m_tvalid,
	input  wire                                m_tready,
	// [2:0] channel_number, [19:3] position, [20] left_button,
	// [21] right_button, [23:22] zero
	output logic [sjpd_pkg::TDATA_OUT_W-1:0]   m_tdata,
	output logic                               m_tuser    // [0] report_kind
);
	import sjpd_pkg::*;

	localparam int unsigned IDX_W = (ANALOG_CHANNELS > 1) ? $clog2(ANALOG_CHANNELS) : 1;
	localparam logic [CHAN_W-1:0] ANALOG_LIMIT = CHAN_W'(ANALOG_CHANNELS);

	// input register
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              cal_s1;

	// framing and calibration state
	logic                 awaiting_q;
	logic [6:0]           held_q;
	logic [READING_W-1:0] rest_q [ANALOG_CHANNELS];

	// result register
	logic             kind_q;
	logic [CHAN_W-1:0] chan_q;
	logic [POS_W-1:0] pos_q;
	logic             left_q;
	logic             right_q;

	logic                 is_second;
	logic                 pair_done;
	logic [CHAN_W-1:0]    chan;
	logic [READING_W-1:0] reading;
	logic                 is_button;
	logic                 is_analog;
	logic                 res_valid;
	logic                 go;
	logic [IDX_W-1:0]     idx;
	logic [READING_W-1:0] rest_eff;
	logic                 rest_wr;
	logic [READING_W:0]   diff;
	logic [READING_W-1:0] mag;
	logic [SCALE_W-1:0]   scale;
	logic                 clamp;
	logic [PROD_W-1:0]    prod;
	logic [POS_W-1:0]     quot;
	logic                 neg;
	logic [POS_W-1:0]     pos;

	// framing
	assign is_second = byte_s1[BYTE_W-1];
	assign pair_done = valid_s1 && is_second && awaiting_q;
	assign chan      = held_q[5:3];
	assign reading   = {held_q[2:0], byte_s1[6:0]};
	assign is_button = (chan == BUTTON_CHAN);
	assign is_analog = (chan < ANALOG_LIMIT);
	assign res_valid = pair_done && (is_button || is_analog);

	// stage advances unless a report has nowhere to go
	assign go       = !res_valid || !m_tvalid || m_tready;
	assign s_tready = !valid_s1 || go;

	// rest value, with this pair's calibration applied before use
	assign idx      = chan[IDX_W-1:0];
	assign rest_wr  = pair_done && is_analog && cal_s1 && go;
	assign rest_eff = cal_s1 ? ((chan == SLIDER_CHAN) ? REST_CENTER : reading) : rest_q[idx];

	// scaling: |diff| * 2^16 / scale via reciprocal; clamp when 2|diff| >= scale
	assign diff  = {1'b0, rest_eff} - {1'b0, reading};
	assign mag   = diff[READING_W] ? READING_W'(-diff) : diff[READING_W-1:0];
	assign scale = chan_scale(chan);
	assign clamp = ({1'b0, mag} << 1) >= scale;
	assign prod  = PROD_W'(mag) * PROD_W'(chan_recip(chan));
	assign quot  = clamp ? HALF_SCALE : {1'b0, prod[RECIP_SHIFT +: QUOT_W]};
	assign neg   = diff[READING_W] ^ (chan == SLIDER_CHAN);
	assign pos   = neg ? (~quot + POS_W'(1)) : quot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			cal_s1  <= s_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q <= 1'b0;
			held_q     <= '0;
		end else if (valid_s1 && go) begin
			if (!is_second) begin
				held_q     <= byte_s1[6:0];
				awaiting_q <= 1'b1;
			end else begin
				awaiting_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ANALOG_CHANNELS; i++) begin
				rest_q[i] <= REST_CENTER;
			end
		end else if (rest_wr) begin
			for (int i = 0; i < ANALOG_CHANNELS; i++) begin
				if (idx == IDX_W'(i)) begin
					rest_q[i] <= rest_eff;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (res_valid && go) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && go) begin
			kind_q  <= is_button ? KIND_BUTTON : KIND_ANALOG;
			chan_q  <= chan;
			pos_q   <= is_button ? '0 : pos;
			left_q  <= is_button && !byte_s1[0];
			right_q <= is_button && !byte_s1[1];
		end
	end

	assign m_tdata = {2'b00, right_q, left_q, pos_q, chan_q};
	assign m_tuser = kind_q;

	// checks
	a_button_zero_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == KIND_BUTTON) |-> (pos_q == '0 && chan_q == BUTTON_CHAN))
		else $error("button report with nonzero position or wrong channel");

	a_analog_range: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == KIND_ANALOG) |->
		(!left_q && !right_q && ($signed(pos_q) <= 32768) && ($signed(pos_q) >= -32768)))
		else $error("analog report out of range or with button bits");

	a_slider_rest: assert property (@(posedge clk) disable iff (!arst_n)
		rest_q[0] == REST_CENTER)
		else $error("slider rest value moved off center");

	a_first_arms: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && go && !is_second) |=> awaiting_q)
		else $error("first byte did not arm pair framing");

	a_second_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && go && is_second) |=> !awaiting_q)
		else $error("second byte left framing armed");

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// Testbench for serial_joystick_pair_decoder: directed and random byte streams,
// checked report by report against an in-bench decoder under random idling and stalls.
// Depends on sjpd_pkg and serial_joystick_pair_decoder.
`timescale 1ns / 1ps

module tb_top;
	import sjpd_pkg::*;

	localparam int N_ANALOG    = MAX_ANALOG;
	localparam int MARK_BIT    = 7;     // set on the second byte of a pair
	localparam int END_CYCLES  = 16;    // well past the report latency
	localparam int PHASE_BYTES = 300;
	localparam int HOLD_CYCLES = 400;
	localparam int MAX_PRINTS  = 40;

	// one expected report, fields as the decoder defines them
	typedef struct packed {
		logic                    kind;
		logic [CHAN_W-1:0]       chan;
		logic signed [POS_W-1:0] pos;
		logic                    left;
		logic                    right;
	} report_t;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [BYTE_W-1:0]      s_tdata  = '0;   // [7:0] rx_byte
	logic                   s_tuser  = 1'b0; // [0] calibrate
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	// [2:0] channel_number, [19:3] position, [20] left_button,
	// [21] right_button, [23:22] zero
	logic [TDATA_OUT_W-1:0] m_tdata;
	logic                   m_tuser;         // [0] report_kind

	// decoder state mirrored in the bench
	logic                 want_second = 1'b0;
	logic [6:0]           held_byte   = '0;
	logic [READING_W-1:0] rest_val [N_ANALOG];

	report_t expected_reports [$];

	int idle_pct  = 0;   // chance per cycle that the sender holds back
	int stall_pct = 0;   // chance per cycle that the receiver drops tready
	int hold_left = 0;   // long receiver hold-off, counted down below

	int err_count = 0;
	int n_bytes   = 0;
	int n_analog  = 0;
	int n_button  = 0;
	int n_clamped = 0;
	int n_cal     = 0;

	always #6 clk = ~clk;

	serial_joystick_pair_decoder #(
		.ANALOG_CHANNELS(N_ANALOG)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	task automatic note_mismatch(input string what, input int got, input int want);
		err_count++;
		if (err_count <= MAX_PRINTS)
			$display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
	endtask

	// Frames one accepted byte and returns 1 with the report it completes.
	function automatic bit decode_byte(input logic [7:0] b, input logic cal, output report_t rep);
		logic [6:0]           low;
		logic [CHAN_W-1:0]    ch;
		logic [READING_W-1:0] reading;
		int                   diff, q, scale;
		rep = '0;
		if (!b[MARK_BIT]) begin
			// first byte: a new one always replaces whatever was held
			held_byte   = b[6:0];
			want_second = 1'b1;
			return 1'b0;
		end
		if (!want_second)
			return 1'b0;   // stray second byte
		want_second = 1'b0;
		low      = b[6:0];
		ch       = held_byte[5:3];   // bit 6 of the first byte is ignored
		rep.chan = ch;
		if (ch == BUTTON_CHAN) begin
			// buttons are active low on the link
			rep.kind  = KIND_BUTTON;
			rep.left  = ~low[0];
			rep.right = ~low[1];
			n_button++;
			return 1'b1;
		end
		if (int'(ch) >= N_ANALOG)
			return 1'b0;
		reading = {held_byte[2:0], low};
		if (cal) begin
			rest_val[ch] = (ch == SLIDER_CHAN) ? REST_CENTER : reading;
			n_cal++;
		end
		case (int'(ch))
			0:       scale = 1019;
			3, 6:    scale = 350;
			default: scale = 200;
		endcase
		diff = int'(rest_val[ch]) - int'(reading);
		q    = (diff * 65536) / scale;   // int division truncates toward zero
		if (q > int'(HALF_SCALE) || q < -int'(HALF_SCALE))
			n_clamped++;
		if (q > int'(HALF_SCALE))
			q = int'(HALF_SCALE);
		if (q < -int'(HALF_SCALE))
			q = -int'(HALF_SCALE);
		if (ch == SLIDER_CHAN)
			q = -q;
		rep.kind = KIND_ANALOG;
		rep.pos  = q[POS_W-1:0];
		n_analog++;
		return 1'b1;
	endfunction

	// Output check comes before input prediction, so a report can never be
	// matched against an expectation pushed at the same edge.
	always @(posedge clk) begin : watch_ports
		report_t got, want, rep;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.kind  = m_tuser;
				got.chan  = m_tdata[2:0];
				got.pos   = m_tdata[19:3];
				got.left  = m_tdata[20];
				got.right = m_tdata[21];
				if (m_tdata[23:22] != 2'b00)
					note_mismatch("pad bits", int'(m_tdata[23:22]), 0);
				if (expected_reports.size() == 0) begin
					note_mismatch("report with none pending, tdata", int'(m_tdata), 0);
				end else begin
					want = expected_reports.pop_front();
					if (got.kind != want.kind)
						note_mismatch("report_kind", int'(got.kind), int'(want.kind));
					if (got.chan != want.chan)
						note_mismatch("channel_number", int'(got.chan), int'(want.chan));
					if (got.pos != want.pos)
						note_mismatch("position", int'(got.pos), int'(want.pos));
					if (got.left != want.left)
						note_mismatch("left_button", int'(got.left), int'(want.left));
					if (got.right != want.right)
						note_mismatch("right_button", int'(got.right), int'(want.right));
				end
			end
			if (s_tvalid && s_tready) begin
				n_bytes++;
				if (decode_byte(s_tdata, s_tuser, rep))
					expected_reports.push_back(rep);
			end
		end
	end

	// Receiver: random stalls, or a long hold-off when one is armed.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_tready = 1'b0;
			hold_left--;
		end else begin
			m_tready = ($urandom_range(99) >= stall_pct);
		end
	end

	// Offers one byte, with random gaps first; returns at the accepting edge.
	task automatic send_req(input logic [7:0] b, input logic cal);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid = 1'b0;
			s_tdata  = 8'($urandom);
			s_tuser  = 1'($urandom);
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = b;
		s_tuser  = cal;
		do @(posedge clk); while (!s_tready);
	endtask

	// A well-formed pair; bit 6 and the flag on the first byte are don't-cares.
	task automatic send_pair(input int ch, input int rd, input logic cal);
		logic [7:0] first;
		first = {1'b0, 1'($urandom_range(1)), 3'(ch), 3'(rd >> 7)};
		send_req(first, 1'($urandom_range(1)));
		send_req({1'b1, 7'(rd)}, cal);
	endtask

	// Lowers the request and waits for every pending report.
	task automatic wait_drained();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (expected_reports.size() != 0)
			@(negedge clk);
	endtask

	// Mostly well-formed pairs, some noise bytes that break the framing.
	task automatic send_traffic(input int n_req);
		int sent, ch, rd;
		sent = 0;
		while (sent < n_req) begin
			if ($urandom_range(99) < 84) begin
				ch = $urandom_range(7);
				case ($urandom_range(3))
					0: rd = $urandom_range(1023);
					1: rd = $urandom_range(1) ? 1023 : 0;
					default: begin
						// near the rest value, so that many results fall short of the clamp
						rd = (ch < N_ANALOG) ? int'(rest_val[ch]) : 512;
						rd = rd + int'($urandom_range(240)) - 120;
						if (rd < 0)
							rd = 0;
						if (rd > 1023)
							rd = 1023;
					end
				endcase
				send_pair(ch, rd, $urandom_range(99) < 12);
				sent += 2;
			end else begin
				send_req(8'($urandom), 1'($urandom_range(1)));
				sent++;
			end
		end
	endtask

	task automatic test_framing_cases();
		idle_pct  = 0;
		stall_pct = 0;
		send_req(8'hC5, 1'b0);     // stray second byte while hunting
		send_req(8'hFF, 1'b1);
		send_req(8'h38, 1'b0);     // buttons, both pressed
		send_req(8'h80, 1'b0);
		send_req(8'h78, 1'b0);     // buttons with bit 6 set, none pressed
		send_req(8'h83, 1'b0);
		send_req(8'h3F, 1'b0);     // buttons, calibrate has no effect
		send_req(8'hFD, 1'b1);
		send_req(8'h0D, 1'b0);     // first byte replaced before its pair completes
		send_req(8'h1A, 1'b0);
		send_req(8'hFF, 1'b0);
		send_pair(1, 0, 1'b0);     // positive clamp
		send_pair(1, 1023, 1'b0);  // negative clamp
		send_pair(0, 0, 1'b0);     // slider, clamped then negated
		send_pair(0, 1023, 1'b0);
		send_pair(2, 512, 1'b0);   // at rest
		send_pair(4, 700, 1'b1);   // calibrate captures the reading
		send_pair(4, 0, 1'b0);
		send_pair(0, 100, 1'b1);   // slider rest stays centered
		send_pair(6, 1023, 1'b1);
		wait_drained();
	endtask

	task automatic run_phase(input int idle, input int stall, input int n_req);
		idle_pct  = idle;
		stall_pct = stall;
		send_traffic(n_req);
		wait_drained();
	endtask

	// Receiver holds off while the sender keeps offering, so the input stalls.
	task automatic test_output_hold();
		idle_pct  = 0;
		stall_pct = 0;
		@(negedge clk);
		hold_left = HOLD_CYCLES;
		send_traffic(120);
		wait_drained();
	endtask

	// Sender stops until every report has come out, then resumes.
	task automatic test_pause_for_drain();
		idle_pct  = 0;
		stall_pct = 40;
		send_traffic(20);
		wait_drained();
		send_traffic(20);
		wait_drained();
	endtask

	initial begin
		for (int i = 0; i < N_ANALOG; i++)
			rest_val[i] = REST_CENTER;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_framing_cases();
		run_phase(0, 0, PHASE_BYTES);
		run_phase(78, 0, PHASE_BYTES);
		run_phase(0, 78, PHASE_BYTES);
		run_phase(11, 11, PHASE_BYTES);
		test_output_hold();
		test_pause_for_drain();

		stall_pct = 0;
		wait_drained();
		repeat (END_CYCLES) @(negedge clk);
		if (expected_reports.size() != 0)
			note_mismatch("reports never delivered", expected_reports.size(), 0);
		$display("run covered %0d bytes: %0d analog and %0d button reports,",
			n_bytes, n_analog, n_button);
		$display("%0d clamped positions, %0d calibrations, %0d mismatches",
			n_clamped, n_cal, err_count);
		if (err_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#(4_000_000);
		$display("timeout waiting on the decoder");
		$display("status: fail");
		$finish;
	end

endmodule

>>> serial_joystick_pair_decoder.f
sv/sjpd_pkg.sv
sv/serial_joystick_pair_decoder.sv
tb/sv/tb_top.sv
